[src/sle_pkg.sv]
// Shared constants, codes and control types of the sorted list engine.
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int HELD_W   = 5;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_DUMP   = 2'd3;

  localparam stat_t ST_DONE      = 2'd0;
  localparam stat_t ST_EMPTY     = 2'd1;
  localparam stat_t ST_NOT_FOUND = 2'd2;
  localparam stat_t ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] key;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] head;
  } ctrl_t;

endpackage

[src/sle_if.sv]
// Request and response channel interfaces of the sorted list engine.
interface sle_req_if;
  import sle_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface sle_rsp_if;
  import sle_pkg::*;
  logic                    valid;
  logic                    ready;
  stat_t                   status;
  logic signed [VAL_W-1:0] entry_value;
  logic [HELD_W-1:0]       entries_held;
  logic                    last_of_run;
  modport source (output valid, status, entry_value, entries_held, last_of_run, input ready);
  modport sink (input valid, status, entry_value, entries_held, last_of_run, output ready);
endinterface

[src/sle_cell.sv]
// One storage cell of the sorted chain: holds a value, compares, shifts.
module sle_cell (
  input  logic                            clk,
  input  sle_pkg::ctrl_t                  ctrl,
  input  logic [sle_pkg::IDX_W-1:0]       idx,
  input  logic signed [sle_pkg::VAL_W-1:0] left_val,
  input  logic                            left_gt,
  input  logic signed [sle_pkg::VAL_W-1:0] right_val,
  output logic signed [sle_pkg::VAL_W-1:0] val,
  output logic                            gt,
  output logic                            eq
);
  import sle_pkg::*;

  logic             occ;
  logic             lt;
  logic             at_end;
  logic             at_tail;
  logic [CNT_W-1:0] pos;

  assign pos     = CNT_W'(idx);
  assign occ     = pos < ctrl.count;
  assign at_end  = pos == ctrl.count;
  assign at_tail = pos == (ctrl.count - CNT_W'(1));
  assign gt      = occ && (val > ctrl.key);
  assign lt      = occ && (val < ctrl.key);
  assign eq      = occ && (val == ctrl.key);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (left_gt) begin
          val <= left_val;
        end else if (gt || at_end) begin
          val <= ctrl.key;
        end
      end
      CMD_DELETE: begin
        if (occ && !lt) begin
          val <= right_val;
        end
      end
      CMD_ROTATE: begin
        val <= at_tail ? ctrl.head : right_val;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/sle_chain.sv]
// Row of sorted cells with neighbor links, head tap and match reduction.
module sle_chain (
  input  logic                             clk,
  input  sle_pkg::ctrl_t                   ctrl,
  output logic signed [sle_pkg::VAL_W-1:0] head,
  output logic                             found
);
  import sle_pkg::*;

  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]     gts;
  logic [CAPACITY-1:0]     eqs;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] lv;
    logic                    lg;
    logic signed [VAL_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end
    sle_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (IDX_W'(i)),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (vals[i]),
      .gt        (gts[i]),
      .eq        (eqs[i])
    );
  end

  assign head  = vals[0];
  assign found = |eqs;

endmodule

[src/sorted_list_engine.sv]
// Top level of the sorted list engine: sequencer, count and result register.
//
// Holds up to CAPACITY signed values in nondecreasing order in a row of cells.
// Request channel (req): operation and value; accepted when valid and ready.
// Response channel (rsp): status, entry_value, entries_held, last_of_run.
// Insert, delete and search: once accepted and with the result register
// free, all cells compare against the value in parallel and an insert or
// delete shifts them in one step; the result is registered at that edge and
// shown the next cycle. A new request is taken while that result waits.
// Dump: the cells rotate once per emitted entry, one entry per cycle after
// the first while rsp is not stalled, and no new request is taken until the
// last entry is registered; an empty dump gives a single empty status.
// When rsp is stalled the result register holds and the sequencer waits;
// no result is lost.
// Reset (rst, synchronous) clears the count and control state; cell contents
// are left as they are and only entries below the count are ever read.
module sorted_list_engine (
  input logic     clk,
  input logic     rst,
  sle_req_if.sink req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP} state_t;

  state_t                  state;
  op_t                     op_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        dump_left;
  logic                    out_valid;
  stat_t                   out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [HELD_W-1:0]       out_held;
  logic                    out_last;

  ctrl_t                   ctrl;
  logic signed [VAL_W-1:0] head;
  logic                    found;
  logic                    slot_free;
  logic                    full;
  logic                    empty;

  assign slot_free = !out_valid || rsp.ready;
  assign full      = count >= CNT_W'(CAPACITY);
  assign empty     = count == '0;

  always_comb begin
    ctrl.cmd   = CMD_HOLD;
    ctrl.key   = key_q;
    ctrl.count = count;
    ctrl.head  = head;
    if (state == S_EXEC && slot_free) begin
      case (op_q)
        OP_INSERT: ctrl.cmd = full ? CMD_HOLD : CMD_INSERT;
        OP_DELETE: ctrl.cmd = (!empty && found) ? CMD_DELETE : CMD_HOLD;
        default:   ctrl.cmd = CMD_HOLD;
      endcase
    end else if (state == S_DUMP && slot_free) begin
      ctrl.cmd = CMD_ROTATE;
    end
  end

  sle_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .head  (head),
    .found (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      dump_left <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
          if (req.valid) begin
            op_q  <= req.operation;
            key_q <= req.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            out_value <= '0;
            out_last  <= 1'b1;
            case (op_q)
              OP_INSERT: begin
                out_valid <= 1'b1;
                state     <= S_IDLE;
                if (full) begin
                  out_status <= ST_FULL;
                  out_held   <= HELD_W'(count);
                end else begin
                  out_status <= ST_DONE;
                  count      <= count + CNT_W'(1);
                  out_held   <= HELD_W'(count + CNT_W'(1));
                end
              end
              OP_DUMP: begin
                out_held <= HELD_W'(count);
                if (empty) begin
                  out_valid  <= 1'b1;
                  out_status <= ST_EMPTY;
                  state      <= S_IDLE;
                end else begin
                  out_valid <= 1'b0;
                  dump_left <= count;
                  state     <= S_DUMP;
                end
              end
              default: begin
                out_valid <= 1'b1;
                state     <= S_IDLE;
                if (empty) begin
                  out_status <= ST_EMPTY;
                  out_held   <= HELD_W'(count);
                end else if (!found) begin
                  out_status <= ST_NOT_FOUND;
                  out_held   <= HELD_W'(count);
                end else if (op_q == OP_DELETE) begin
                  out_status <= ST_DONE;
                  count      <= count - CNT_W'(1);
                  out_held   <= HELD_W'(count - CNT_W'(1));
                end else begin
                  out_status <= ST_DONE;
                  out_held   <= HELD_W'(count);
                end
              end
            endcase
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_DONE;
            out_value  <= head;
            out_held   <= HELD_W'(count);
            out_last   <= dump_left == CNT_W'(1);
            dump_left  <= dump_left - CNT_W'(1);
            if (dump_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = state == S_IDLE;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.entry_value  = out_value;
  assign rsp.entries_held = out_held;
  assign rsp.last_of_run  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |->
      (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_dump_left: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> dump_left != '0)
    else $error("dump running with nothing left");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_EXEC)
    else $error("accepted item not executed");

endmodule

[tb/sv/tb.sv]
// Testbench of the sorted list engine: directed table, random episodes, in-order result check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int RANDOM_ITEMS    = 413;
  localparam int N_DIRECTED      = 24;
  localparam int PRESSURE_AFTER  = 120;
  localparam int PRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 32;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX, GEN_NOISE} gen_mode_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pat_t;

  typedef struct {
    stat_t                   status;
    logic signed [VAL_W-1:0] entry_value;
    logic [HELD_W-1:0]       entries_held;
    logic                    last_of_run;
  } list_result_t;

  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] val;
    int                      reps;
    bit                      typed;
    stat_t                   e_status;
    logic [HELD_W-1:0]       e_held;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  sorted_list_engine dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic signed [VAL_W-1:0] model_entries [CAPACITY];
  int                      model_count = 0;
  list_result_t            pending_results [$];

  stim_row_t directed_rows [N_DIRECTED];
  int        fails          = 0;
  int        accepted_items = 0;
  int        idle_cycles    = 0;
  bit        stim_done      = 1'b0;

  gen_mode_t gen_mode   = GEN_MIX;
  int        gen_left   = 0;
  int        fill_extra = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void predict_list_op(op_t op, logic signed [VAL_W-1:0] v);
    int pos;
    pos = model_count;
    if (op == OP_INSERT) begin
      if (model_count >= CAPACITY) begin
        pending_results.push_back('{ST_FULL, '0, HELD_W'(model_count), 1'b1});
      end else begin
        for (int i = 0; i < model_count; i++) begin
          if (model_entries[i] > v) begin
            pos = i;
            break;
          end
        end
        for (int i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
        model_entries[pos] = v;
        model_count++;
        pending_results.push_back('{ST_DONE, '0, HELD_W'(model_count), 1'b1});
      end
    end else if (op == OP_DUMP) begin
      if (model_count == 0) begin
        pending_results.push_back('{ST_EMPTY, '0, HELD_W'(0), 1'b1});
      end else begin
        for (int i = 0; i < model_count; i++) begin
          pending_results.push_back('{ST_DONE, model_entries[i], HELD_W'(model_count),
                                      (i == model_count - 1)});
        end
      end
    end else if (model_count == 0) begin
      pending_results.push_back('{ST_EMPTY, '0, HELD_W'(0), 1'b1});
    end else begin
      for (int i = 0; i < model_count; i++) begin
        if (model_entries[i] == v) begin
          pos = i;
          break;
        end
      end
      if (pos == model_count) begin
        pending_results.push_back('{ST_NOT_FOUND, '0, HELD_W'(model_count), 1'b1});
      end else begin
        if (op == OP_DELETE) begin
          for (int i = pos; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
        pending_results.push_back('{ST_DONE, '0, HELD_W'(model_count), 1'b1});
      end
    end
  endfunction

  // Episodes: fill to full and beyond, drain by held values, mixed traffic, raw noise.
  task automatic next_random(output op_t op, output logic signed [VAL_W-1:0] v);
    int roll;
    roll = $urandom_range(0, 99);
    if (gen_left == 0) begin
      if (roll < 35) gen_mode = GEN_FILL;
      else if (roll < 65) gen_mode = GEN_DRAIN;
      else if (roll < 90) gen_mode = GEN_MIX;
      else gen_mode = GEN_NOISE;
      gen_left = (gen_mode == GEN_FILL || gen_mode == GEN_DRAIN) ? 1000 : $urandom_range(8, 40);
      fill_extra = $urandom_range(1, 3);
    end
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      4, 5: v = int'($urandom_range(0, 16)) - 8;
      default: v = (model_count > 0) ? model_entries[$urandom_range(0, model_count - 1)]
                                     : $urandom;
    endcase
    roll = $urandom_range(0, 99);
    case (gen_mode)
      GEN_FILL: begin
        if (model_count < CAPACITY) begin
          op = (roll < 85) ? OP_INSERT : OP_SEARCH;
        end else if (fill_extra > 0) begin
          op = OP_INSERT;
          fill_extra--;
        end else begin
          op = OP_DUMP;
          gen_left = 1;
        end
      end
      GEN_DRAIN: begin
        if (model_count > 0) begin
          if (roll < 70) begin
            op = OP_DELETE;
            v = model_entries[$urandom_range(0, model_count - 1)];
          end else if (roll < 80) begin
            op = OP_DELETE;
          end else if (roll < 92) begin
            op = OP_SEARCH;
          end else begin
            op = OP_DUMP;
          end
        end else begin
          op = op_t'($urandom_range(1, 3));
          gen_left = 1;
        end
      end
      GEN_MIX: begin
        if (roll < 40) op = OP_INSERT;
        else if (roll < 60) op = OP_DELETE;
        else if (roll < 80) op = OP_SEARCH;
        else op = OP_DUMP;
      end
      default: begin
        op = op_t'($urandom_range(0, 3));
        v = $urandom;
      end
    endcase
    gen_left--;
  endtask

  // Request side: bursts and gaps; prediction at each accepted item.
  initial begin
    int           row;
    int           rep;
    int           rand_done;
    int           burst_left;
    int           gap_left;
    bit           offering;
    bit           cur_typed;
    list_result_t cur_exp;
    op_t          nop;
    logic signed [VAL_W-1:0] nval;

    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.value     = '0;
    row        = 0;
    rep        = 0;
    rand_done  = 0;
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;
    offering   = 1'b0;
    cur_typed  = 1'b0;
    cur_exp    = '{ST_DONE, '0, '0, 1'b1};

    directed_rows = '{
      '{OP_DUMP,   32'h0000_0000, 1,  1'b1, ST_EMPTY,     5'd0},
      '{OP_DELETE, 32'h0000_0005, 1,  1'b1, ST_EMPTY,     5'd0},
      '{OP_SEARCH, 32'hFFFF_FFFB, 1,  1'b1, ST_EMPTY,     5'd0},
      '{OP_INSERT, VAL_MAX,       1,  1'b1, ST_DONE,      5'd1},
      '{OP_INSERT, VAL_MIN,       1,  1'b1, ST_DONE,      5'd2},
      '{OP_INSERT, 32'h0000_0000, 1,  1'b1, ST_DONE,      5'd3},
      '{OP_INSERT, 32'h0000_0000, 1,  1'b1, ST_DONE,      5'd4},
      '{OP_INSERT, 32'hFFFF_FFFF, 1,  1'b1, ST_DONE,      5'd5},
      '{OP_SEARCH, VAL_MIN,       1,  1'b1, ST_DONE,      5'd5},
      '{OP_SEARCH, 32'h5555_5555, 1,  1'b1, ST_NOT_FOUND, 5'd5},
      '{OP_DUMP,   32'hFFFF_FFFF, 1,  1'b0, ST_DONE,      5'd0},
      '{OP_DELETE, 32'h0000_0000, 1,  1'b1, ST_DONE,      5'd4},
      '{OP_DELETE, 32'hAAAA_AAAA, 1,  1'b1, ST_NOT_FOUND, 5'd4},
      '{OP_SEARCH, VAL_MAX,       1,  1'b1, ST_DONE,      5'd4},
      '{OP_DELETE, VAL_MIN,       1,  1'b1, ST_DONE,      5'd3},
      '{OP_DELETE, VAL_MAX,       1,  1'b1, ST_DONE,      5'd2},
      '{OP_DUMP,   32'h0000_0000, 1,  1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'h0000_0064, 14, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'h0000_0001, 1,  1'b1, ST_FULL,      5'd16},
      '{OP_DUMP,   32'h0000_0000, 1,  1'b0, ST_DONE,      5'd0},
      '{OP_SEARCH, 32'h0000_0057, 1,  1'b1, ST_DONE,      5'd16},
      '{OP_DELETE, 32'h0000_0064, 1,  1'b1, ST_DONE,      5'd15},
      '{OP_INSERT, VAL_MIN,       1,  1'b1, ST_DONE,      5'd16},
      '{OP_DUMP,   32'h0000_0000, 1,  1'b0, ST_DONE,      5'd0}
    };

    while (!stim_done) begin
      @(posedge clk);
      if (!rst) begin
        if (req_ch.valid && req_ch.ready) begin
          predict_list_op(req_ch.operation, req_ch.value);
          if (cur_typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(cur_exp);
          end
          accepted_items++;
          offering = 1'b0;
        end
        if (!offering) begin
          if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
          end else if (row < N_DIRECTED || rand_done < RANDOM_ITEMS) begin
            if (row < N_DIRECTED) begin
              nop       = directed_rows[row].op;
              nval      = directed_rows[row].val - rep;
              cur_typed = directed_rows[row].typed;
              cur_exp   = '{directed_rows[row].e_status, '0, directed_rows[row].e_held, 1'b1};
              rep++;
              if (rep >= directed_rows[row].reps) begin
                rep = 0;
                row++;
              end
            end else begin
              next_random(nop, nval);
              cur_typed = 1'b0;
              rand_done++;
            end
            req_ch.valid     <= 1'b1;
            req_ch.operation <= nop;
            req_ch.value     <= nval;
            offering = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end
          end else begin
            req_ch.valid <= 1'b0;
            stim_done = 1'b1;
          end
        end
      end
    end
  end

  // Response side: changing stall patterns, plus one long hold-off to back up the block.
  initial begin
    rx_pat_t pat;
    int      pat_left;
    int      hold_left;
    bit      held_done;

    rsp_ch.ready = 1'b0;
    pat       = RX_OPEN;
    pat_left  = 0;
    hold_left = 0;
    held_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_done && accepted_items >= PRESSURE_AFTER) begin
        held_done = 1'b1;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat      = rx_pat_t'($urandom_range(0, 3));
          pat_left = $urandom_range(20, 120);
        end
        pat_left--;
        case (pat)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ch.ready <= ~rsp_ch.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d entry_value %0d entries_held %0d last_of_run %0d",
               rsp_ch.status, rsp_ch.entry_value, rsp_ch.entries_held, rsp_ch.last_of_run);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
          fails++;
        end
        if (rsp_ch.entry_value !== exp_r.entry_value) begin
          $error("entry_value: expected %0d, got %0d", exp_r.entry_value, rsp_ch.entry_value);
          fails++;
        end
        if (rsp_ch.entries_held !== exp_r.entries_held) begin
          $error("entries_held: expected %0d, got %0d", exp_r.entries_held,
                 rsp_ch.entries_held);
          fails++;
        end
        if (rsp_ch.last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", exp_r.last_of_run, rsp_ch.last_of_run);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $error("timeout: no item moved for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, pending_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sle_pkg.sv
src/sle_if.sv
src/sle_cell.sv
src/sle_chain.sv
src/sorted_list_engine.sv
tb/sv/tb.sv
